[sv/edh_pkg.sv]
// edh_pkg: sizes, codes and state type of the euclidean distance histogram unit
// no dependencies; used by the interfaces, the top level and its ram instances
package edh_pkg;

  localparam int MAX_DIMENSIONS = 128;
  localparam int HISTOGRAM_BINS = 4096;

  localparam int FUNC_W  = 2;
  localparam int COORD_W = 8;
  localparam int BIN_W   = 12;
  localparam int DIST_W  = 12;
  localparam int COUNT_W = 32;
  localparam int SUM_W   = 24;
  localparam int DIMS_W  = 8;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 8'd100;

  // coordinate position counter and the active dimension count
  localparam int CNT_W = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
  localparam int ACT_W = CNT_W + 1;

  localparam int HIST_AW = $clog2(HISTOGRAM_BINS);

  // serial square and serial root
  localparam int PROD_W     = 2 * COORD_W;
  localparam int MUL_CW     = $clog2(COORD_W);
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int SQ_CW      = $clog2(SQRT_STEPS);
  localparam int REM_W      = DIST_W + 1;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_REF   = 2'd0,
    FUNC_POINT = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic {
    KIND_POINT = 1'b0,
    KIND_BIN   = 1'b1
  } kind_t;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_REF_RD  = 8'b0000_0100,
    S_MUL     = 8'b0000_1000,
    S_ACC     = 8'b0001_0000,
    S_SQRT    = 8'b0010_0000,
    S_SLOT    = 8'b0100_0000,
    S_HIST_RD = 8'b1000_0000
  } state_t;

endpackage

[sv/edh_if.sv]
// edh_if: valid/ready channel interfaces for requests, results and configuration
// depends on edh_pkg for the field widths
interface edh_in_if;
  logic                        valid;
  logic                        ready;
  logic [edh_pkg::FUNC_W-1:0]  func;
  logic [edh_pkg::COORD_W-1:0] coordinate;
  logic [edh_pkg::BIN_W-1:0]   bin_index;

  modport source (output valid, func, coordinate, bin_index, input ready);
  modport sink   (input valid, func, coordinate, bin_index, output ready);
endinterface

interface edh_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [edh_pkg::DIST_W-1:0]  distance;
  logic [edh_pkg::COUNT_W-1:0] count;

  modport source (output valid, kind, distance, count, input ready);
  modport sink   (input valid, kind, distance, count, output ready);
endinterface

interface edh_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [edh_pkg::DIMS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[sv/edh_ram.sv]
// edh_ram: generic single write port, single read port ram with registered read
// no dependencies
module edh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/euclidean_distance_histogram_unit.sv]
// reference coordinate: written without leaving idle. compared coordinate: ref read, serial
// square and saturating add; the last one of a point adds a two-bits-a-cycle root, a bin address
// step and a histogram read, then its result is loaded once the result register is free. bin
// read or clear: histogram read as the request is taken, result loaded likewise; one request is
// in work at a time. after reset a clearing pass zeroes the histogram ram with in_ch.ready low;
// cfg writes are taken throughout. depends on edh_pkg, edh_if and edh_ram
module euclidean_distance_histogram_unit (
  input logic      clk,
  input logic      rst_n,
  edh_in_if.sink   in_ch,
  edh_out_if.source out_ch,
  edh_cfg_if.sink  cfg_ch
);

  edh_pkg::state_t state_r, state_nxt;
  logic [edh_pkg::DIMS_W-1:0]  dims_r, dims_nxt;
  logic [edh_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [edh_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [edh_pkg::HIST_AW-1:0] clr_r, clr_nxt;
  logic [edh_pkg::MUL_CW-1:0]  mstep_r, mstep_nxt;
  logic [edh_pkg::SQ_CW-1:0]   sstep_r, sstep_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        last_r, last_nxt;
  logic [edh_pkg::COORD_W-1:0] coord_r, coord_nxt;
  edh_pkg::func_t              func_r, func_nxt;
  logic [edh_pkg::BIN_W-1:0]   bin_r, bin_nxt;
  logic                        in_range_r, in_range_nxt;
  logic [edh_pkg::HIST_AW-1:0] hist_addr_r, hist_addr_nxt;
  logic [edh_pkg::PROD_W-1:0]  mcand_r, mcand_nxt;
  logic [edh_pkg::COORD_W-1:0] mplier_r, mplier_nxt;
  logic [edh_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [edh_pkg::SUM_W-1:0]   vsh_r, vsh_nxt;
  logic [edh_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [edh_pkg::DIST_W-1:0]  root_r, root_nxt;
  edh_pkg::kind_t              out_kind_r, out_kind_nxt;
  logic [edh_pkg::DIST_W-1:0]  out_dist_r, out_dist_nxt;
  logic [edh_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic                        ref_we, ref_re;
  logic [edh_pkg::COORD_W-1:0] ref_rdata;
  logic                        hist_we, hist_re;
  logic [edh_pkg::HIST_AW-1:0] hist_waddr, hist_raddr;
  logic [edh_pkg::COUNT_W-1:0] hist_wdata, hist_rdata;

  logic                        in_fire, out_free;
  logic [edh_pkg::ACT_W-1:0]   active;
  logic                        cnt_last;
  logic [edh_pkg::CNT_W-1:0]   cnt_adv;
  logic [edh_pkg::COORD_W-1:0] diff;
  logic [edh_pkg::SUM_W:0]     sum_ext;
  logic [edh_pkg::SUM_W-1:0]   sum_sat;
  logic [edh_pkg::REM_W+1:0]   rem_sh, trial;
  logic [edh_pkg::COUNT_W-1:0] cnt_inc;

  edh_ram #(
    .WIDTH (edh_pkg::COORD_W),
    .DEPTH (edh_pkg::MAX_DIMENSIONS)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (cnt_r),
    .wdata (in_ch.coordinate),
    .re    (ref_re),
    .raddr (cnt_r),
    .rdata (ref_rdata)
  );

  edh_ram #(
    .WIDTH (edh_pkg::COUNT_W),
    .DEPTH (edh_pkg::HISTOGRAM_BINS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign in_ch.ready  = (state_r == edh_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.distance = out_dist_r;
  assign out_ch.count    = out_count_r;

  // zero acts as one, anything above the ram depth as the depth
  always_comb begin
    if (dims_r == '0) begin
      active = edh_pkg::ACT_W'(1);
    end else if (32'(dims_r) > 32'(edh_pkg::MAX_DIMENSIONS)) begin
      active = edh_pkg::ACT_W'(edh_pkg::MAX_DIMENSIONS);
    end else begin
      active = edh_pkg::ACT_W'(dims_r);
    end
  end

  assign cnt_last = ({1'b0, cnt_r} + edh_pkg::ACT_W'(1)) >= active;
  assign cnt_adv  = cnt_last ? '0 : cnt_r + edh_pkg::CNT_W'(1);

  assign diff    = (coord_r >= ref_rdata) ? coord_r - ref_rdata : ref_rdata - coord_r;
  assign sum_ext = {1'b0, sum_r} + (edh_pkg::SUM_W + 1)'(prod_r);
  assign sum_sat = sum_ext[edh_pkg::SUM_W] ? edh_pkg::SUM_MAX : sum_ext[edh_pkg::SUM_W-1:0];
  assign rem_sh  = {rem_r, vsh_r[edh_pkg::SUM_W-1 -: 2]};
  assign trial   = (edh_pkg::REM_W + 2)'({root_r, 2'b01});
  assign cnt_inc = (hist_rdata == edh_pkg::COUNT_MAX) ? hist_rdata
                                                     : hist_rdata + edh_pkg::COUNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    dims_nxt      = dims_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    clr_nxt       = clr_r;
    mstep_nxt     = mstep_r;
    sstep_nxt     = sstep_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    last_nxt      = last_r;
    coord_nxt     = coord_r;
    func_nxt      = func_r;
    bin_nxt       = bin_r;
    in_range_nxt  = in_range_r;
    hist_addr_nxt = hist_addr_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    prod_nxt      = prod_r;
    vsh_nxt       = vsh_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    out_kind_nxt  = out_kind_r;
    out_dist_nxt  = out_dist_r;
    out_count_nxt = out_count_r;
    ref_we        = 1'b0;
    ref_re        = 1'b0;
    hist_we       = 1'b0;
    hist_re       = 1'b0;
    hist_waddr    = hist_addr_r;
    hist_wdata    = '0;
    hist_raddr    = hist_addr_r;

    if (cfg_ch.valid) begin
      dims_nxt = cfg_ch.data;
    end

    case (state_r)
      edh_pkg::S_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_r;
        clr_nxt    = clr_r + edh_pkg::HIST_AW'(1);
        if (clr_r == edh_pkg::HIST_AW'(edh_pkg::HISTOGRAM_BINS - 1)) begin
          state_nxt = edh_pkg::S_IDLE;
        end
      end
      edh_pkg::S_IDLE: begin
        if (in_fire) begin
          case (edh_pkg::func_t'(in_ch.func))
            edh_pkg::FUNC_REF: begin
              ref_we  = 1'b1;
              cnt_nxt = cnt_adv;
            end
            edh_pkg::FUNC_POINT: begin
              ref_re    = 1'b1;
              coord_nxt = in_ch.coordinate;
              last_nxt  = cnt_last;
              cnt_nxt   = cnt_adv;
              state_nxt = edh_pkg::S_REF_RD;
            end
            default: begin
              func_nxt      = edh_pkg::func_t'(in_ch.func);
              bin_nxt       = in_ch.bin_index;
              in_range_nxt  = 32'(in_ch.bin_index) < 32'(edh_pkg::HISTOGRAM_BINS);
              hist_re       = 1'b1;
              hist_raddr    = edh_pkg::HIST_AW'(in_ch.bin_index);
              hist_addr_nxt = edh_pkg::HIST_AW'(in_ch.bin_index);
              state_nxt     = edh_pkg::S_HIST_RD;
            end
          endcase
        end
      end
      edh_pkg::S_REF_RD: begin
        mcand_nxt  = edh_pkg::PROD_W'(diff);
        mplier_nxt = diff;
        prod_nxt   = '0;
        mstep_nxt  = '0;
        state_nxt  = edh_pkg::S_MUL;
      end
      edh_pkg::S_MUL: begin
        // one multiplier bit a cycle
        if (mplier_r[0]) begin
          prod_nxt = prod_r + mcand_r;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        mstep_nxt  = mstep_r + edh_pkg::MUL_CW'(1);
        if (mstep_r == edh_pkg::MUL_CW'(edh_pkg::COORD_W - 1)) begin
          state_nxt = edh_pkg::S_ACC;
        end
      end
      edh_pkg::S_ACC: begin
        if (last_r) begin
          vsh_nxt   = sum_sat;
          sum_nxt   = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          sstep_nxt = '0;
          state_nxt = edh_pkg::S_SQRT;
        end else begin
          sum_nxt   = sum_sat;
          state_nxt = edh_pkg::S_IDLE;
        end
      end
      edh_pkg::S_SQRT: begin
        // restoring root, two radicand bits a cycle
        if (rem_sh >= trial) begin
          rem_nxt  = edh_pkg::REM_W'(rem_sh - trial);
          root_nxt = {root_r[edh_pkg::DIST_W-2:0], 1'b1};
        end else begin
          rem_nxt  = edh_pkg::REM_W'(rem_sh);
          root_nxt = {root_r[edh_pkg::DIST_W-2:0], 1'b0};
        end
        vsh_nxt   = vsh_r << 2;
        sstep_nxt = sstep_r + edh_pkg::SQ_CW'(1);
        if (sstep_r == edh_pkg::SQ_CW'(edh_pkg::SQRT_STEPS - 1)) begin
          state_nxt = edh_pkg::S_SLOT;
        end
      end
      edh_pkg::S_SLOT: begin
        // distances past the last bin count in the last bin
        if (32'(root_r) < 32'(edh_pkg::HISTOGRAM_BINS)) begin
          hist_addr_nxt = edh_pkg::HIST_AW'(root_r);
        end else begin
          hist_addr_nxt = edh_pkg::HIST_AW'(edh_pkg::HISTOGRAM_BINS - 1);
        end
        hist_re    = 1'b1;
        hist_raddr = hist_addr_nxt;
        func_nxt   = edh_pkg::FUNC_POINT;
        state_nxt  = edh_pkg::S_HIST_RD;
      end
      edh_pkg::S_HIST_RD: begin
        // ram read data holds while the result register is still full
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = edh_pkg::S_IDLE;
          case (func_r)
            edh_pkg::FUNC_POINT: begin
              hist_we       = 1'b1;
              hist_wdata    = cnt_inc;
              out_kind_nxt  = edh_pkg::KIND_POINT;
              out_dist_nxt  = root_r;
              out_count_nxt = cnt_inc;
            end
            default: begin
              hist_we       = (func_r == edh_pkg::FUNC_CLEAR) && in_range_r;
              out_kind_nxt  = edh_pkg::KIND_BIN;
              out_dist_nxt  = edh_pkg::DIST_W'(bin_r);
              out_count_nxt = in_range_r ? hist_rdata : '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = edh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edh_pkg::S_CLEAR;
      dims_r      <= edh_pkg::DIMS_RESET;
      cnt_r       <= '0;
      sum_r       <= '0;
      clr_r       <= '0;
      mstep_r     <= '0;
      sstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dims_r      <= dims_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      clr_r       <= clr_nxt;
      mstep_r     <= mstep_nxt;
      sstep_r     <= sstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    coord_r     <= coord_nxt;
    func_r      <= func_nxt;
    bin_r       <= bin_nxt;
    in_range_r  <= in_range_nxt;
    hist_addr_r <= hist_addr_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    prod_r      <= prod_nxt;
    vsh_r       <= vsh_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    out_kind_r  <= out_kind_nxt;
    out_dist_r  <= out_dist_nxt;
    out_count_r <= out_count_nxt;
  end

  a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == edh_pkg::S_CLEAR) |-> (hist_we && hist_wdata == '0 && !in_ch.ready))
    else $error("clearing pass not writing zero or taking requests");

  a_point_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == edh_pkg::KIND_POINT) |-> (out_count_r != '0))
    else $error("point result with zero count");

  a_ref_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && edh_pkg::func_t'(in_ch.func) == edh_pkg::FUNC_REF) |=>
      (state_r == edh_pkg::S_IDLE))
    else $error("reference coordinate request left idle");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == edh_pkg::S_HIST_RD && out_free) |=> out_valid_r)
    else $error("histogram result not loaded");

endmodule
